### hw/rtl/assert_macros.svh
// Assertion helpers shared by the block. Both sample on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CFER_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cfer assertion failed");

// Checked on every edge, reset included.
`define CFER_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("cfer reset assertion failed");

`endif

### hw/rtl/cfer_pkg.sv
package cfer_pkg;

    localparam int MAG_W     = 32;
    localparam int SQ_W      = 64;
    localparam int NUM_W     = 128;
    localparam int MUL_B_W   = 64;
    localparam int PROD_W    = 192;
    localparam int TERM_W    = 132;
    localparam int OUT_W     = 63;
    localparam int SCALE_W   = 32;
    localparam int E_SHIFT   = 20;
    localparam int M_SHIFT   = 60;
    localparam int O_SHIFT   = 16;
    localparam int NUM_COMP  = 3;
    localparam int NUM_SUM   = 6;
    localparam int K_W       = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

    typedef struct packed {
        logic [NUM_COMP-1:0][MAG_W-1:0] e_mag;
        logic [NUM_COMP-1:0][MAG_W-1:0] b_mag;
        logic [NUM_COMP-1:0][MAG_W-1:0] h_mag;
        logic [MAG_W-1:0]               jac;
        logic                           ok;
        logic                           last;
    } t_cell;

    typedef struct packed {
        logic pop;
        logic load;
    } t_back_stat;

endpackage

### hw/rtl/cfer_if.sv
interface cfer_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] e_xi;
    logic [31:0] e_eta;
    logic [31:0] e_mu;
    logic [31:0] b_xi;
    logic [31:0] b_eta;
    logic [31:0] b_mu;
    logic [31:0] scale_one;
    logic [31:0] scale_two;
    logic [31:0] scale_three;
    logic [31:0] jacobian;
    logic        last_cell;

    modport source (output valid, e_xi, e_eta, e_mu, b_xi, b_eta, b_mu, scale_one,
                    scale_two, scale_three, jacobian, last_cell, input ready);
    modport sink (input valid, e_xi, e_eta, e_mu, b_xi, b_eta, b_mu, scale_one,
                  scale_two, scale_three, jacobian, last_cell, output ready);
endinterface

interface cfer_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] energy_e_xi;
    logic [62:0] energy_e_eta;
    logic [62:0] energy_e_mu;
    logic [62:0] energy_b_xi;
    logic [62:0] energy_b_eta;
    logic [62:0] energy_b_mu;
    logic        saturated;

    modport source (output valid, energy_e_xi, energy_e_eta, energy_e_mu, energy_b_xi,
                    energy_b_eta, energy_b_mu, saturated, input ready);
    modport sink (input valid, energy_e_xi, energy_e_eta, energy_e_mu, energy_b_xi,
                  energy_b_eta, energy_b_mu, saturated, output ready);
endinterface

### hw/rtl/cfer_front.sv
module cfer_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    cfer_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output cfer_pkg::t_cell  o_cell
);

    // Returns {negative, magnitude} of the low SAMPLE_WIDTH bits.
    function automatic logic [cfer_pkg::MAG_W:0] mag(input logic [31:0] raw);
        logic [SAMPLE_WIDTH-1:0] v;
        logic [SAMPLE_WIDTH-1:0] m;
        v = raw[SAMPLE_WIDTH-1:0];
        m = v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
        return {v[SAMPLE_WIDTH-1], cfer_pkg::MAG_W'(m)};
    endfunction

    logic [cfer_pkg::MAG_W:0] h0, h1, h2, jc;
    logic [cfer_pkg::MAG_W:0] ex, ee, em, bx, be, bm;

    assign h0 = mag(i_in.scale_one);
    assign h1 = mag(i_in.scale_two);
    assign h2 = mag(i_in.scale_three);
    assign jc = mag(i_in.jacobian);
    assign ex = mag(i_in.e_xi);
    assign ee = mag(i_in.e_eta);
    assign em = mag(i_in.e_mu);
    assign bx = mag(i_in.b_xi);
    assign be = mag(i_in.b_eta);
    assign bm = mag(i_in.b_mu);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cell.e_mag[0] = ex[cfer_pkg::MAG_W-1:0];
        o_cell.e_mag[1] = ee[cfer_pkg::MAG_W-1:0];
        o_cell.e_mag[2] = em[cfer_pkg::MAG_W-1:0];
        o_cell.b_mag[0] = bx[cfer_pkg::MAG_W-1:0];
        o_cell.b_mag[1] = be[cfer_pkg::MAG_W-1:0];
        o_cell.b_mag[2] = bm[cfer_pkg::MAG_W-1:0];
        o_cell.h_mag[0] = h0[cfer_pkg::MAG_W-1:0];
        o_cell.h_mag[1] = h1[cfer_pkg::MAG_W-1:0];
        o_cell.h_mag[2] = h2[cfer_pkg::MAG_W-1:0];
        o_cell.jac      = jc[cfer_pkg::MAG_W-1:0];
        // A cell counts only if every scale factor and the Jacobian are positive.
        o_cell.ok = !h0[cfer_pkg::MAG_W] && (h0[cfer_pkg::MAG_W-1:0] != '0) &&
                    !h1[cfer_pkg::MAG_W] && (h1[cfer_pkg::MAG_W-1:0] != '0) &&
                    !h2[cfer_pkg::MAG_W] && (h2[cfer_pkg::MAG_W-1:0] != '0) &&
                    !jc[cfer_pkg::MAG_W] && (jc[cfer_pkg::MAG_W-1:0] != '0);
        o_cell.last = i_in.last_cell;
    end

endmodule

### hw/rtl/cfer_queue.sv
module cfer_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  cfer_pkg::t_cell               i_cell,
    input  logic                          i_pop,
    output cfer_pkg::t_cell               o_cell,
    output logic [cfer_pkg::Q_CNT_W-1:0]  o_count
);

    localparam int Q_CNT_W = cfer_pkg::Q_CNT_W;

    cfer_pkg::t_cell                r_mem [cfer_pkg::Q_DEPTH];
    logic [cfer_pkg::Q_PTR_W-1:0]   r_wptr, r_rptr;
    logic [cfer_pkg::Q_CNT_W-1:0]   r_count;

    assign o_cell  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

endmodule

### hw/rtl/cfer_mul.sv
module cfer_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfer_pkg::NUM_W-1:0]    i_a,
    input  logic [cfer_pkg::MUL_B_W-1:0]  i_b,
    output logic                          o_done,
    output logic [cfer_pkg::PROD_W-1:0]   o_p
);

    localparam int LAST = 8;

    logic [cfer_pkg::NUM_W-1:0]    r_a;
    logic [cfer_pkg::MUL_B_W-1:0]  r_b;
    logic [cfer_pkg::PROD_W-1:0]   r_acc;
    logic [cfer_pkg::SQ_W-1:0]     r_part;
    logic [2:0]                    r_sh;
    logic [3:0]                    r_cnt;
    logic                          r_busy, r_pv, r_done;
    logic [2:0]                    sh;

    assign o_done = r_done;
    assign o_p    = r_acc;
    assign sh     = {1'b0, r_cnt[1:0]} + {2'b0, r_cnt[2]};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_pv) begin
                r_acc <= r_acc + (cfer_pkg::PROD_W'(r_part) << {r_sh, 5'b0});
            end
            r_part <= r_a[{r_cnt[1:0], 5'b0} +: cfer_pkg::MAG_W] *
                      r_b[{r_cnt[2], 5'b0} +: cfer_pkg::MAG_W];
            r_sh   <= sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_pv  <= (r_cnt != 4'(LAST));
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 4'(LAST)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### hw/rtl/cfer_div.sv
module cfer_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfer_pkg::NUM_W-1:0]    i_num,
    input  logic [cfer_pkg::SQ_W-1:0]     i_den,
    output logic                          o_done,
    output logic [cfer_pkg::NUM_W-1:0]    o_q
);

    logic [cfer_pkg::NUM_W-1:0]  r_num, r_q;
    logic [cfer_pkg::SQ_W-1:0]   r_den, r_rem;
    logic [6:0]                  r_cnt;
    logic                        r_busy, r_done;
    logic [cfer_pkg::SQ_W:0]     trial;
    logic                        fits;

    assign trial  = {r_rem, r_num[cfer_pkg::NUM_W-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_q    = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[cfer_pkg::NUM_W-2:0], 1'b0};
            r_rem <= fits ? cfer_pkg::SQ_W'(trial - {1'b0, r_den})
                          : trial[cfer_pkg::SQ_W-1:0];
            r_q   <= {r_q[cfer_pkg::NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### hw/rtl/cfer_back.sv
module cfer_back #(
    parameter int SUM_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfer_pkg::SCALE_W-1:0]   i_cfg_data,
    input  cfer_pkg::t_cell                i_cell,
    input  logic                           i_avail,
    output logic                           o_pop,
    output cfer_pkg::t_back_stat           o_stat,
    cfer_out_if.source                     o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_H2    = 4'd1;
    localparam logic [3:0] S_E2    = 4'd2;
    localparam logic [3:0] S_N     = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_B2    = 4'd5;
    localparam logic [3:0] S_M     = 4'd6;
    localparam logic [3:0] S_W     = 4'd7;
    localparam logic [3:0] S_OWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int K_W    = cfer_pkg::K_W;
    localparam int TERM_W = cfer_pkg::TERM_W;
    localparam int OUT_W  = cfer_pkg::OUT_W;
    localparam int SC_W   = cfer_pkg::PROD_W - cfer_pkg::O_SHIFT;

    logic [3:0]                   r_state, n_state;
    logic [K_W-1:0]               r_k, n_k;
    logic                         r_pend, n_pend;
    cfer_pkg::t_cell              r_cell, n_cell;
    logic [cfer_pkg::SQ_W-1:0]    r_h2, n_h2, r_e2, n_e2, r_b2, n_b2;
    logic [cfer_pkg::NUM_W-1:0]   r_m, n_m;
    logic [SUM_WIDTH-1:0]         r_sum [cfer_pkg::NUM_SUM];
    logic [SUM_WIDTH-1:0]         n_sum [cfer_pkg::NUM_SUM];
    logic                         r_ovf, n_ovf;
    logic [cfer_pkg::SCALE_W-1:0] r_scale, n_scale;
    logic [OUT_W-1:0]             r_o [cfer_pkg::NUM_SUM];
    logic [OUT_W-1:0]             n_o [cfer_pkg::NUM_SUM];
    logic                         r_osat, n_osat, r_ovalid, n_ovalid;

    logic                         mul_start, mul_done, div_start, div_done, load;
    logic [cfer_pkg::NUM_W-1:0]   mul_a, div_q;
    logic [cfer_pkg::MUL_B_W-1:0] mul_b;
    logic [cfer_pkg::PROD_W-1:0]  mul_p;
    logic [K_W-1:0]               sum_idx;
    logic [TERM_W-1:0]            term_src;
    logic                         term_over, acc_over, o_over;
    logic [SUM_WIDTH-1:0]         term, acc_val;
    logic [SUM_WIDTH:0]           acc_sum;
    logic [SC_W-1:0]              scaled;
    logic [OUT_W-1:0]             o_val;

    cfer_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    cfer_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (cfer_pkg::NUM_W'(mul_p[cfer_pkg::NUM_W-1:0] << cfer_pkg::E_SHIFT)),
        .i_den   (r_h2),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign sum_idx   = (r_state == S_W) ? K_W'(r_k + K_W'(cfer_pkg::NUM_COMP)) : r_k;
    assign term_src  = (r_state == S_W) ? TERM_W'(mul_p >> cfer_pkg::M_SHIFT)
                                        : TERM_W'(div_q);
    assign term_over = |term_src[TERM_W-1:SUM_WIDTH];
    assign term      = term_over ? '1 : term_src[SUM_WIDTH-1:0];
    assign acc_sum   = {1'b0, r_sum[sum_idx]} + {1'b0, term};
    assign acc_over  = acc_sum[SUM_WIDTH];
    assign acc_val   = acc_over ? '1 : acc_sum[SUM_WIDTH-1:0];
    assign scaled    = mul_p[cfer_pkg::PROD_W-1:cfer_pkg::O_SHIFT];
    assign o_over    = |scaled[SC_W-1:OUT_W];
    assign o_val     = o_over ? '1 : scaled[OUT_W-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_H2: begin
                mul_a = cfer_pkg::NUM_W'(r_cell.h_mag[r_k[1:0]]);
                mul_b = cfer_pkg::MUL_B_W'(r_cell.h_mag[r_k[1:0]]);
            end
            S_E2: begin
                mul_a = cfer_pkg::NUM_W'(r_cell.e_mag[r_k[1:0]]);
                mul_b = cfer_pkg::MUL_B_W'(r_cell.e_mag[r_k[1:0]]);
            end
            S_N: begin
                mul_a = cfer_pkg::NUM_W'(r_e2);
                mul_b = cfer_pkg::MUL_B_W'(r_cell.jac);
            end
            S_B2: begin
                mul_a = cfer_pkg::NUM_W'(r_cell.b_mag[r_k[1:0]]);
                mul_b = cfer_pkg::MUL_B_W'(r_cell.b_mag[r_k[1:0]]);
            end
            S_M: begin
                mul_a = cfer_pkg::NUM_W'(r_b2);
                mul_b = r_h2;
            end
            S_W: begin
                mul_a = r_m;
                mul_b = cfer_pkg::MUL_B_W'(r_cell.jac);
            end
            S_OUT: begin
                mul_a = cfer_pkg::NUM_W'(r_sum[r_k]);
                mul_b = cfer_pkg::MUL_B_W'(r_scale);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_pend    = r_pend;
        n_cell    = r_cell;
        n_h2      = r_h2;
        n_e2      = r_e2;
        n_b2      = r_b2;
        n_m       = r_m;
        n_sum     = r_sum;
        n_ovf     = r_ovf;
        n_scale   = r_scale;
        n_o       = r_o;
        n_osat    = r_osat;
        n_ovalid  = r_ovalid;
        mul_start = 1'b0;
        div_start = 1'b0;
        o_pop     = 1'b0;
        load      = 1'b0;

        if (i_cfg_we) begin
            n_scale = i_cfg_data;
        end
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop  = 1'b1;
                    n_cell = i_cell;
                    n_k    = '0;
                    if (i_cell.ok) begin
                        n_state = S_H2;
                    end else if (i_cell.last) begin
                        n_state = S_OWAIT;
                    end
                end
            end
            S_H2, S_E2, S_N, S_B2, S_M, S_W, S_OUT: begin
                if (!r_pend) begin
                    mul_start = 1'b1;
                    n_pend    = 1'b1;
                end else if (mul_done) begin
                    n_pend = 1'b0;
                    case (r_state)
                        S_H2: begin
                            n_h2    = mul_p[cfer_pkg::SQ_W-1:0];
                            n_state = S_E2;
                        end
                        S_E2: begin
                            n_e2    = mul_p[cfer_pkg::SQ_W-1:0];
                            n_state = S_N;
                        end
                        S_N: begin
                            n_state = S_DIV;
                        end
                        S_B2: begin
                            n_b2    = mul_p[cfer_pkg::SQ_W-1:0];
                            n_state = S_M;
                        end
                        S_M: begin
                            n_m     = mul_p[cfer_pkg::NUM_W-1:0];
                            n_state = S_W;
                        end
                        S_W: begin
                            n_sum[sum_idx] = acc_val;
                            n_ovf          = r_ovf || term_over || acc_over;
                            if (r_k == K_W'(cfer_pkg::NUM_COMP - 1)) begin
                                n_k     = '0;
                                n_state = r_cell.last ? S_OWAIT : S_IDLE;
                            end else begin
                                n_k     = r_k + 1'b1;
                                n_state = S_H2;
                            end
                        end
                        default: begin
                            n_o[r_k] = o_val;
                            if (r_k == K_W'(cfer_pkg::NUM_SUM - 1)) begin
                                for (int i = 0; i < cfer_pkg::NUM_SUM; i++) begin
                                    n_sum[i] = '0;
                                end
                                n_osat   = r_ovf || o_over;
                                n_ovf    = 1'b0;
                                n_ovalid = 1'b1;
                                n_k      = '0;
                                n_state  = S_IDLE;
                            end else begin
                                n_ovf = r_ovf || o_over;
                                n_k   = r_k + 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (!r_pend) begin
                    div_start = 1'b1;
                    n_pend    = 1'b1;
                end else if (div_done) begin
                    n_pend         = 1'b0;
                    n_sum[sum_idx] = acc_val;
                    n_ovf          = r_ovf || term_over || acc_over;
                    n_state        = S_B2;
                end
            end
            S_OWAIT: begin
                if (!r_ovalid) begin
                    load    = 1'b1;
                    n_k     = '0;
                    n_state = S_OUT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_pend   <= 1'b0;
            r_ovf    <= 1'b0;
            r_scale  <= cfer_pkg::SCALE_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < cfer_pkg::NUM_SUM; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_pend   <= n_pend;
            r_ovf    <= n_ovf;
            r_scale  <= n_scale;
            r_ovalid <= n_ovalid;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        r_h2   <= n_h2;
        r_e2   <= n_e2;
        r_b2   <= n_b2;
        r_m    <= n_m;
        r_o    <= n_o;
        r_osat <= n_osat;
    end

    assign o_stat.pop  = o_pop;
    assign o_stat.load = load;

    assign o_out.valid        = r_ovalid;
    assign o_out.energy_e_xi  = r_o[0];
    assign o_out.energy_e_eta = r_o[1];
    assign o_out.energy_e_mu  = r_o[2];
    assign o_out.energy_b_xi  = r_o[3];
    assign o_out.energy_b_eta = r_o[4];
    assign o_out.energy_b_mu  = r_o[5];
    assign o_out.saturated    = r_osat;

endmodule

### hw/rtl/curvilinear_field_energy_reduce_top.sv
// Field energy reduction over a sweep of grid cells.
// i_in carries one cell per word: E and B components, scale factors and the
// Jacobian, plus a last_cell mark. o_out carries one word per sweep with the
// six scaled energy sums and a saturation flag. i_cfg_we with i_cfg_data
// writes the energy scale; write it only while the block is idle.
// A two-entry queue sits between the input stage and the arithmetic engine,
// so i_in stays ready while fewer than two cells wait to be processed.
// The engine shares one 32x32 multiplier, used over eight partial products
// per wide product, and one divider that retires one quotient bit a cycle.
// A valid cell leaves the queue, then takes six products and one division
// per component; a skipped cell only leaves the queue. A last cell then
// claims the output register and runs six output products before its word
// appears on o_out. If o_out is stalled, the result word holds and the
// engine waits only when the next sweep ends; cells keep flowing in until
// the queue fills. Reset clears the sums, the saturation flag, the queue and
// o_out.valid, and sets the energy scale to 1.0.
`include "assert_macros.svh"

module curvilinear_field_energy_reduce_top #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int SUM_WIDTH    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    cfer_in_if.sink     i_in,
    cfer_out_if.source  o_out
);

    cfer_pkg::t_cell               f_cell, q_cell;
    cfer_pkg::t_back_stat          stat;
    logic                          push, pop;
    logic [cfer_pkg::Q_CNT_W-1:0]  q_count;

    cfer_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_in   (i_in),
        .i_full (q_count == cfer_pkg::Q_CNT_W'(cfer_pkg::Q_DEPTH)),
        .o_push (push),
        .o_cell (f_cell)
    );

    cfer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (f_cell),
        .i_pop   (pop),
        .o_cell  (q_cell),
        .o_count (q_count)
    );

    cfer_back #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cell     (q_cell),
        .i_avail    (q_count != '0),
        .o_pop      (pop),
        .o_stat     (stat),
        .o_out      (o_out)
    );

    `CFER_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_out.valid)
    `CFER_ASSERT(a_pop_avail, stat.pop |-> (q_count != '0))
    `CFER_ASSERT(a_load_free, stat.load |-> !o_out.valid)

endmodule

### tb/curvilinear_field_energy_reduce_top_tb.sv
module curvilinear_field_energy_reduce_top_tb;

    localparam int        DRAIN_CYCLES = 2000;
    localparam int        HOLD_CYCLES  = 3000;
    localparam int        WATCH_LIMIT  = 20000;
    localparam logic [63:0] SUM_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] ENERGY_MAX = {63{1'b1}};

    typedef struct {
        logic [31:0] e[3];
        logic [31:0] b[3];
        logic [31:0] h[3];
        logic [31:0] jac;
        logic        last;
    } t_cell_word;

    typedef struct {
        logic [62:0] energy[6];
        logic        saturated;
    } t_sweep_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_data;

    cfer_in_if  cell_if ();
    cfer_out_if res_if ();

    curvilinear_field_energy_reduce_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (cell_if),
        .o_out      (res_if)
    );

    logic [31:0]   scale_reg;
    logic [63:0]   sum_reg[6];
    logic          sat_reg;
    t_sweep_result sweep_queue[$];
    int            fail_count;
    int            cells_sent;
    int            sweeps_checked;
    int            idle_cycles;
    int            hold_requests;
    int            hold_served;
    int            hold_count;
    int            stall_count;

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [63:0] clamp_term(logic [191:0] v, ref logic sat);
        if (v > {128'd0, SUM_MAX}) begin
            sat = 1'b1;
            return SUM_MAX;
        end
        return v[63:0];
    endfunction

    task automatic add_to_sum(int k, logic [63:0] c);
        logic [64:0] s;
        s = {1'b0, sum_reg[k]} + {1'b0, c};
        if (s[64]) begin
            sum_reg[k] = SUM_MAX;
            sat_reg = 1'b1;
        end else begin
            sum_reg[k] = s[63:0];
        end
    endtask

    // Updates the running sums for one cell and queues the sweep result on the last one.
    task automatic predict_cell(t_cell_word c);
        logic [63:0]   hm[3];
        logic [63:0]   jm;
        logic [63:0]   h2, e2, b2;
        logic [127:0]  num, quo;
        logic [191:0]  prod;
        logic [95:0]   scaled;
        logic [79:0]   shifted;
        logic          ok;
        t_sweep_result r;
        ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            hm[k] = {32'd0, c.h[k]};
            if (c.h[k][31] || c.h[k] == 0) ok = 1'b0;
        end
        jm = {32'd0, c.jac};
        if (c.jac[31] || c.jac == 0) ok = 1'b0;
        if (ok) begin
            for (int k = 0; k < 3; k++) begin
                h2 = hm[k] * hm[k];
                e2 = {32'd0, magnitude(c.e[k])} * {32'd0, magnitude(c.e[k])};
                b2 = {32'd0, magnitude(c.b[k])} * {32'd0, magnitude(c.b[k])};
                num = (128'(jm) * 128'(e2)) << 20;
                quo = num / 128'(h2);
                add_to_sum(k, clamp_term(192'(quo), sat_reg));
                prod = 192'(b2) * 192'(h2) * 192'(jm);
                add_to_sum(3 + k, clamp_term(prod >> 60, sat_reg));
            end
        end
        if (c.last) begin
            for (int k = 0; k < 6; k++) begin
                scaled  = 96'(sum_reg[k]) * 96'(scale_reg);
                shifted = scaled[95:16];
                if (shifted > 80'(ENERGY_MAX)) begin
                    r.energy[k] = ENERGY_MAX;
                    sat_reg = 1'b1;
                end else begin
                    r.energy[k] = shifted[62:0];
                end
                sum_reg[k] = '0;
            end
            r.saturated = sat_reg;
            sat_reg = 1'b0;
            sweep_queue.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_sweep_result exp_r;
        logic [62:0]   got[6];
        string         names[6];
        names = '{"energy_e_xi", "energy_e_eta", "energy_e_mu",
                  "energy_b_xi", "energy_b_eta", "energy_b_mu"};
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.energy_e_xi, res_if.energy_e_eta, res_if.energy_e_mu,
                    res_if.energy_b_xi, res_if.energy_b_eta, res_if.energy_b_mu};
            if (sweep_queue.size() == 0) begin
                $error("result word with no sweep expected");
                fail_count++;
            end else begin
                exp_r = sweep_queue.pop_front();
                sweeps_checked++;
                for (int k = 0; k < 6; k++) begin
                    if (got[k] !== exp_r.energy[k]) begin
                        $error("%s expected %0d actual %0d", names[k], exp_r.energy[k], got[k]);
                        fail_count++;
                    end
                end
                if (res_if.saturated !== exp_r.saturated) begin
                    $error("saturated expected %0b actual %0b", exp_r.saturated,
                           res_if.saturated);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_count  <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            res_if.ready <= 1'b0;
        end else if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_count <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 900)
                                                        : $urandom_range(0, 4);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("curvilinear_field_energy_reduce_top_tb: errors");
                $finish;
            end
        end
    end

    task automatic send_cell(t_cell_word c, int gap);
        cell_if.valid       <= 1'b1;
        cell_if.e_xi        <= c.e[0];
        cell_if.e_eta       <= c.e[1];
        cell_if.e_mu        <= c.e[2];
        cell_if.b_xi        <= c.b[0];
        cell_if.b_eta       <= c.b[1];
        cell_if.b_mu        <= c.b[2];
        cell_if.scale_one   <= c.h[0];
        cell_if.scale_two   <= c.h[1];
        cell_if.scale_three <= c.h[2];
        cell_if.jacobian    <= c.jac;
        cell_if.last_cell   <= c.last;
        do @(posedge i_clk); while (!cell_if.ready);
        predict_cell(c);
        cells_sent++;
        if (gap > 0) begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 19) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] random_positive();
        case ($urandom_range(0, 4))
            0: return 32'd1;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1, 32'h0040_0000);
            default: return $urandom_range(1, 32'h7FFF_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h0000_FFFF) ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom();
        endcase
    endfunction

    function automatic t_cell_word random_cell(int last_odds);
        t_cell_word c;
        for (int k = 0; k < 3; k++) begin
            c.e[k] = random_sample();
            c.b[k] = random_sample();
            c.h[k] = random_positive();
        end
        c.jac = random_positive();
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
                0: c.h[$urandom_range(0, 2)] = 32'd0;
                1: c.h[$urandom_range(0, 2)] = $urandom() | 32'h8000_0000;
                2: c.jac = 32'd0;
                default: c.jac = $urandom() | 32'h8000_0000;
            endcase
        end
        c.last = ($urandom_range(1, last_odds) == 1);
        return c;
    endfunction

    function automatic t_cell_word make_cell(logic [31:0] e, logic [31:0] b, logic [31:0] h,
                                             logic [31:0] jac, logic last);
        t_cell_word c;
        for (int k = 0; k < 3; k++) begin
            c.e[k] = e;
            c.b[k] = b;
            c.h[k] = h;
        end
        c.jac  = jac;
        c.last = last;
        return c;
    endfunction

    // Lets the block go idle so the scale register can be rewritten safely.
    task automatic wait_idle();
        cell_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sweep_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [31:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scale_reg = value;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_cell_word c;
        send_cell(make_cell(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 1'b1), 0);
        send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0), 1);
        send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b1), 0);
        send_cell(make_cell(32'h8000_0000, 32'h0, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1), 0);
        send_cell(make_cell(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1), 2);
        send_cell(make_cell(32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001, 1'b1), 0);
        send_cell(make_cell(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0010_0000, 1'b1), 0);
        send_cell(make_cell(32'h0040_0000, 32'h0040_0000, 32'hFFFF_FFFF, 32'h0010_0000, 1'b0), 0);
        send_cell(make_cell(32'h0040_0000, 32'h0040_0000, 32'h0010_0000, 32'h0, 1'b0), 0);
        send_cell(make_cell(32'h0040_0000, 32'h0040_0000, 32'h0010_0000, 32'h8000_0000, 1'b1), 0);
        c = make_cell(32'hFFF0_0000, 32'h0020_0000, 32'h0010_0000, 32'h0010_0000, 1'b0);
        c.h[1] = 32'h8000_0000;
        send_cell(c, 0);
        c = make_cell(32'h0123_4567, 32'hFEDC_BA98, 32'h0008_0000, 32'h0030_0000, 1'b0);
        send_cell(c, 0);
        c.last = 1'b1;
        c.h[2] = 32'h0;
        send_cell(c, 0);
        for (int k = 0; k < 6; k++)
            send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                                32'h7FFF_FFFF, 1'b0), 0);
        send_cell(make_cell(32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001, 1'b1), 0);
    endtask

    task automatic test_scale_extremes();
        write_scale(32'hFFFF_FFFF);
        send_cell(make_cell(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 1'b1), 0);
        send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1), 0);
        write_scale(32'd0);
        send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1), 0);
        send_cell(make_cell(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 1'b1), 0);
    endtask

    task automatic test_output_hold();
        hold_requests++;
        for (int n = 0; n < 8; n++)
            send_cell(random_cell(2), 0);
    endtask

    task automatic test_random_sweeps(logic [31:0] scale, int count);
        write_scale(scale);
        for (int n = 0; n < count; n++)
            send_cell(random_cell(8), random_gap());
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        cell_if.valid = 1'b0;
        cell_if.e_xi = '0; cell_if.e_eta = '0; cell_if.e_mu = '0;
        cell_if.b_xi = '0; cell_if.b_eta = '0; cell_if.b_mu = '0;
        cell_if.scale_one = '0; cell_if.scale_two = '0; cell_if.scale_three = '0;
        cell_if.jacobian = '0; cell_if.last_cell = 1'b0;
        scale_reg = cfer_pkg::SCALE_RESET;
        for (int k = 0; k < 6; k++) sum_reg[k] = '0;
        sat_reg = 1'b0;
        fail_count = 0; cells_sent = 0; sweeps_checked = 0;
        hold_requests = 0; hold_served = 0; hold_count = 0; stall_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_hold();
        wait_idle();
        test_scale_extremes();
        test_random_sweeps(32'h0001_0000, 500);
        test_random_sweeps(32'h0000_0001, 450);
        test_random_sweeps($urandom(), 500);
        test_random_sweeps(32'h8000_0000, 500);
        wait_idle();

        $display("Sent %0d cells and checked %0d sweep results over several scale settings,",
                 cells_sent, sweeps_checked);
        $display("including skipped cells, saturation, and a long output stall.");
        if (fail_count == 0) begin
            $display("curvilinear_field_energy_reduce_top_tb: clean");
        end else begin
            $display("curvilinear_field_energy_reduce_top_tb: errors");
        end
        $finish;
    end
endmodule
